FILE: hw/rtl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants for the button debounce block
// Event kinds, queue entry, configuration bundle and register map.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int BTN_W  = 4;
  localparam int TS_W   = 32;
  localparam int CFG_W  = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Largest number of buttons the 4-bit index can reach
  localparam int MAX_BUTTONS = 16;

  localparam int QUEUE_DEPTH = 2;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_REPEAT_DELAY = 2'd1;
  localparam logic [1:0] REG_REPEAT_PER   = 2'd2;
  localparam logic [1:0] REG_REPEAT_MASK  = 2'd3;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd20;
  localparam logic [CFG_W-1:0] RST_REPEAT_DELAY = 16'd500;
  localparam logic [CFG_W-1:0] RST_REPEAT_PER   = 16'd100;
  localparam logic [CFG_W-1:0] RST_REPEAT_MASK  = 16'd512;

  typedef enum logic [1:0] {
    EV_PRESS,
    EV_RELEASE,
    EV_PAIR       // release then press, from auto-repeat
  } ev_kind_e;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    ev_kind_e         kind;
  } ev_t;

  typedef struct packed {
    logic [CFG_W-1:0] settle_ms;
    logic [CFG_W-1:0] rpt_delay_ms;
    logic [CFG_W-1:0] repeat_period_ms;
    logic [CFG_W-1:0] repeat_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hw/rtl/button_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// button_debounce_autorepeat: key debounce with typematic auto-repeat
// Pin samples in, press/release key events out; APB register port.
// ----------------------------------------------------------------------------
// A sample (button index, active-low pin level, millisecond timestamp) is
// taken every cycle while s_axis_tready is high; tready drops only when the
// two-entry event queue is full. Each sample is classified in the cycle it
// is taken: a level held longer than the settle time gives a press or
// release, and a held key whose mask bit is set repeats after the repeat
// delay with a release/press pair every repeat_period_ms. Events leave one
// per cycle through a registered output while m_axis_tready takes them;
// a repeat pair leaves as its release, then its press. tlast marks the
// final event of a sample. Samples with an index at or above BTN_COUNT are
// dropped without any state change. All per-button state resets at once;
// no clearing pass.
// Registers: 0x0 settle time, 0x4 repeat delay, 0x8 repeat_period_ms,
// 0xC repeat_enable_mask, 16 bits each, to be written by the user only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module button_debounce_autorepeat #(
  parameter int BTN_COUNT = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // [3:0] button_index, [4] pin_level,
                                                    // [36:5] now_ms, rest zero
  // key event stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [3:0] button_out, rest zero
  output logic                       m_axis_tuser,  // [0] pressed
  output logic                       m_axis_tlast,  // last_event
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bda_pkg::ADDR_W-1:0] paddr,
  input  logic [bda_pkg::DATA_W-1:0] pwdata,
  output logic [bda_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CFG_W = bda_pkg::CFG_W;

  bda_pkg::cfg_t      cfg_q;
  bda_pkg::ev_t       push_ev, head_ev;
  bda_pkg::q_status_t q_status;
  logic               push, pop;
  logic               wr_en;
  logic [1:0]         reg_idx;
  logic [3:0]         out_button;

  // ---- register file ----
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms          <= bda_pkg::RST_DEBOUNCE;
      cfg_q.rpt_delay_ms       <= bda_pkg::RST_REPEAT_DELAY;
      cfg_q.repeat_period_ms   <= bda_pkg::RST_REPEAT_PER;
      cfg_q.repeat_enable_mask <= bda_pkg::RST_REPEAT_MASK;
    end else if (wr_en) begin
      case (reg_idx)
        bda_pkg::REG_DEBOUNCE:     cfg_q.settle_ms          <= pwdata[CFG_W-1:0];
        bda_pkg::REG_REPEAT_DELAY: cfg_q.rpt_delay_ms       <= pwdata[CFG_W-1:0];
        bda_pkg::REG_REPEAT_PER:   cfg_q.repeat_period_ms   <= pwdata[CFG_W-1:0];
        bda_pkg::REG_REPEAT_MASK:  cfg_q.repeat_enable_mask <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bda_pkg::REG_DEBOUNCE:     prdata = {16'd0, cfg_q.settle_ms};
      bda_pkg::REG_REPEAT_DELAY: prdata = {16'd0, cfg_q.rpt_delay_ms};
      bda_pkg::REG_REPEAT_PER:   prdata = {16'd0, cfg_q.repeat_period_ms};
      bda_pkg::REG_REPEAT_MASK:  prdata = {16'd0, cfg_q.repeat_enable_mask};
      default:                   prdata = '0;
    endcase
  end

  // ---- front: intake and classification ----
  bda_front #(
    .BTN_COUNT(BTN_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .button_i   (s_axis_tdata[3:0]),
    .level_i    (s_axis_tdata[4]),
    .now_i      (s_axis_tdata[36:5]),
    .q_status_i (q_status),
    .push_o     (push),
    .ev_o       (push_ev)
  );

  // ---- event queue ----
  bda_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .ev_i     (push_ev),
    .pop_i    (pop),
    .head_o   (head_ev),
    .status_o (q_status)
  );

  // ---- back: event emission ----
  bda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_ev),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .button_o    (out_button),
    .pressed_o   (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_button};

  // ---- assertions ----
  // the first event of a repeat pair is always the release
  a_pair_head_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !m_axis_tuser)
    else $error("non-final event is not a release");

  // the press of a pair follows its release at once, same button
  a_pair_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser && m_axis_tlast &&
       m_axis_tdata == $past(m_axis_tdata)))
    else $error("repeat pair broken");

  // queue status is never full and empty together
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue status inconsistent");

endmodule

FILE: hw/rtl/bda_front.sv
// ----------------------------------------------------------------------------
// bda_front: sample intake and classification
// Holds per-button debounce and repeat state, turns each sample into at
// most one queued event (press, release or repeat pair).
// ----------------------------------------------------------------------------
module bda_front #(
  parameter int BTN_COUNT = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bda_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bda_pkg::BTN_W-1:0] button_i,
  input  logic                      level_i,
  input  logic [bda_pkg::TS_W-1:0]  now_i,
  input  bda_pkg::q_status_t        q_status_i,
  output logic                      push_o,
  output bda_pkg::ev_t              ev_o
);

  localparam int NB_EFF = (BTN_COUNT < bda_pkg::MAX_BUTTONS) ?
                          BTN_COUNT : bda_pkg::MAX_BUTTONS;
  localparam int IDX_W  = (NB_EFF > 1) ? $clog2(NB_EFF) : 1;
  localparam int TS_W   = bda_pkg::TS_W;

  logic [NB_EFF-1:0] raw_q, stable_q, down_q, rep_q;
  logic [TS_W-1:0]   chg_stamp_q   [NB_EFF];
  logic [TS_W-1:0]   press_stamp_q [NB_EFF];
  logic [TS_W-1:0]   rpt_stamp_q   [NB_EFF];

  logic [IDX_W-1:0] idx;
  logic             accept, hit;
  logic             raw_old, stable_old, down_old, rep_old;
  logic [TS_W-1:0]  chg_diff, press_diff, rpt_diff;
  logic             deb_ok, stab_chg, press, release_ev, rep_allow, rep_start, pair;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign idx        = button_i[IDX_W-1:0];
  assign hit        = accept &&
                      ({{(32-bda_pkg::BTN_W){1'b0}}, button_i} < 32'(NB_EFF));

  assign raw_old    = raw_q[idx];
  assign stable_old = stable_q[idx];
  assign down_old   = down_q[idx];
  assign rep_old    = rep_q[idx];

  // All three time checks use the stored stamps; a stamp rewritten on this
  // sample would give a zero difference, which never exceeds a limit.
  assign chg_diff   = now_i - chg_stamp_q[idx];
  assign press_diff = now_i - press_stamp_q[idx];
  assign rpt_diff   = now_i - rpt_stamp_q[idx];

  always_comb begin
    deb_ok     = (level_i == raw_old) &&
                 (chg_diff > {{(TS_W-bda_pkg::CFG_W){1'b0}}, cfg_i.settle_ms});
    stab_chg   = deb_ok && (level_i != stable_old);
    press      = stab_chg && !level_i && !down_old;
    release_ev = stab_chg && level_i && down_old;
    rep_allow  = !press && !release_ev && down_old && cfg_i.repeat_enable_mask[button_i];
    rep_start  = rep_allow && !rep_old &&
                 (press_diff > {{(TS_W-bda_pkg::CFG_W){1'b0}}, cfg_i.rpt_delay_ms});
    pair       = rep_allow && rep_old &&
                 (rpt_diff > {{(TS_W-bda_pkg::CFG_W){1'b0}}, cfg_i.repeat_period_ms});
  end

  always_comb begin
    push_o       = hit && (press || release_ev || pair);
    ev_o.button  = button_i;
    if (press) begin
      ev_o.kind = bda_pkg::EV_PRESS;
    end else if (release_ev) begin
      ev_o.kind = bda_pkg::EV_RELEASE;
    end else begin
      ev_o.kind = bda_pkg::EV_PAIR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= '1;
      stable_q <= '1;
      down_q   <= '0;
      rep_q    <= '0;
      for (int i = 0; i < NB_EFF; i++) begin
        chg_stamp_q[i]   <= '0;
        press_stamp_q[i] <= '0;
        rpt_stamp_q[i]   <= '0;
      end
    end else if (hit) begin
      raw_q[idx] <= level_i;
      if (level_i != raw_old) chg_stamp_q[idx] <= now_i;
      if (stab_chg) stable_q[idx] <= level_i;
      if (press) begin
        down_q[idx]        <= 1'b1;
        rep_q[idx]         <= 1'b0;
        press_stamp_q[idx] <= now_i;
        rpt_stamp_q[idx]   <= now_i;
      end
      if (release_ev) begin
        down_q[idx] <= 1'b0;
        rep_q[idx]  <= 1'b0;
      end
      if (rep_start) begin
        rep_q[idx]       <= 1'b1;
        rpt_stamp_q[idx] <= now_i;
      end
      if (pair) rpt_stamp_q[idx] <= now_i;
    end
  end

endmodule

FILE: hw/rtl/bda_queue.sv
// ----------------------------------------------------------------------------
// bda_queue: short event queue
// Two-entry FIFO between classifier and event emitter.
// ----------------------------------------------------------------------------
module bda_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bda_pkg::ev_t       ev_i,
  input  logic               pop_i,
  output bda_pkg::ev_t       head_o,
  output bda_pkg::q_status_t status_o
);

  localparam int DEPTH = bda_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bda_pkg::ev_t     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= ev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/bda_back.sv
// ----------------------------------------------------------------------------
// bda_back: event emitter
// Expands queued events into key events, one per cycle while the output is
// not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module bda_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bda_pkg::ev_t              head_i,
  input  bda_pkg::q_status_t        q_status_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bda_pkg::BTN_W-1:0] button_o,
  output logic                      pressed_o,
  output logic                      last_o
);

  logic                      valid_q, valid_d;
  logic                      half_q, half_d;   // first half of a pair sent
  logic [bda_pkg::BTN_W-1:0] button_q, button_d;
  logic                      pressed_q, pressed_d;
  logic                      last_q, last_d;
  logic                      load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d   = valid_q;
    half_d    = half_q;
    button_d  = button_q;
    pressed_d = pressed_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    if (load) begin
      valid_d = 1'b0;
      if (!q_status_i.empty) begin
        valid_d  = 1'b1;
        button_d = head_i.button;
        case (head_i.kind)
          bda_pkg::EV_PRESS: begin
            pressed_d = 1'b1;
            last_d    = 1'b1;
            pop_o     = 1'b1;
          end
          bda_pkg::EV_RELEASE: begin
            pressed_d = 1'b0;
            last_d    = 1'b1;
            pop_o     = 1'b1;
          end
          bda_pkg::EV_PAIR: begin
            if (!half_q) begin
              pressed_d = 1'b0;
              last_d    = 1'b0;
              half_d    = 1'b1;
            end else begin
              pressed_d = 1'b1;
              last_d    = 1'b1;
              half_d    = 1'b0;
              pop_o     = 1'b1;
            end
          end
          default: begin
            pressed_d = 1'b0;
            last_d    = 1'b1;
            pop_o     = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    button_q  <= button_d;
    pressed_q <= pressed_d;
    last_q    <= last_d;
  end

  assign out_valid_o = valid_q;
  assign button_o    = button_q;
  assign pressed_o   = pressed_q;
  assign last_o      = last_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for button_debounce_autorepeat
// Drives pin samples through the stream input and predicts each key event.
// Phases run under several register settings, written over APB while idle.
// Every event leaving the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NBTN        = 16;
  localparam int PHASE_ITEMS = 180;

  typedef struct packed {
    logic [bda_pkg::BTN_W-1:0] btn;
    logic                      lvl;
    logic [bda_pkg::TS_W-1:0]  stamp;
  } sample_t;

  typedef struct packed {
    logic [bda_pkg::BTN_W-1:0] btn;
    logic                      pressed;
    logic                      last;
  } key_ev_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [39:0]                s_axis_tdata  = '0;   // [3:0] button_index, [4] pin_level,
                                                    // [36:5] now_ms
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;         // [3:0] button_out, rest zero
  logic                       m_axis_tuser;         // [0] pressed
  logic                       m_axis_tlast;         // last_event
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [bda_pkg::ADDR_W-1:0] paddr         = '0;
  logic [bda_pkg::DATA_W-1:0] pwdata        = '0;
  logic [bda_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // predictor state, one entry per button
  logic                       raw_lvl    [NBTN];
  logic                       stable_lvl [NBTN];
  logic                       key_held   [NBTN];
  logic                       auto_rep   [NBTN];
  logic [bda_pkg::TS_W-1:0]   chg_ms     [NBTN];
  logic [bda_pkg::TS_W-1:0]   press_ms   [NBTN];
  logic [bda_pkg::TS_W-1:0]   rep_ms     [NBTN];
  bda_pkg::cfg_t              cfg_m;

  sample_t                    sample_q[$];          // samples waiting to be offered
  key_ev_t                    event_q[$];           // key events still to arrive
  sample_t                    next_sample;
  key_ev_t                    seen_ev;
  key_ev_t                    want_ev;
  logic [bda_pkg::TS_W-1:0]   wall_ms;              // virtual millisecond clock
  int                         queued        = 0;
  int                         items_taken   = 0;
  int                         mismatches    = 0;
  int                         hold_left     = 0;
  logic                       hold_done     = 1'b0;
  logic                       calm;

  // no random idling on either side for a stretch of the run
  assign calm = (items_taken >= 700) && (items_taken < 900);

  always #5 clk_i = ~clk_i;

  button_debounce_autorepeat DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // Key event prediction for one accepted sample
  // --------------------------------------------------------------------------
  function automatic void forecast_key_events(sample_t s);
    int                       b;
    logic [bda_pkg::TS_W-1:0] dt;
    key_ev_t                  evs[$];
    b = int'(s.btn);
    if (b >= NBTN) return;
    if (s.lvl != raw_lvl[b]) begin
      chg_ms[b]  = s.stamp;
      raw_lvl[b] = s.lvl;
    end
    dt = s.stamp - chg_ms[b];
    if (dt > {16'b0, cfg_m.settle_ms} && raw_lvl[b] != stable_lvl[b]) begin
      if (raw_lvl[b] == 1'b0) begin
        if (!key_held[b]) begin
          evs.push_back('{btn: s.btn, pressed: 1'b1, last: 1'b0});
          key_held[b] = 1'b1;
          press_ms[b] = s.stamp;
          rep_ms[b]   = s.stamp;
          auto_rep[b] = 1'b0;
        end
      end else if (key_held[b]) begin
        evs.push_back('{btn: s.btn, pressed: 1'b0, last: 1'b0});
        key_held[b] = 1'b0;
        auto_rep[b] = 1'b0;
      end
      stable_lvl[b] = raw_lvl[b];
    end
    // typematic repeat: delay after the press, then a release/press pair per period
    if (key_held[b] && cfg_m.repeat_enable_mask[b]) begin
      dt = s.stamp - press_ms[b];
      if (!auto_rep[b] && dt > {16'b0, cfg_m.rpt_delay_ms}) begin
        auto_rep[b] = 1'b1;
        rep_ms[b]   = s.stamp;
      end
      dt = s.stamp - rep_ms[b];
      if (auto_rep[b] && dt > {16'b0, cfg_m.repeat_period_ms}) begin
        evs.push_back('{btn: s.btn, pressed: 1'b0, last: 1'b0});
        evs.push_back('{btn: s.btn, pressed: 1'b1, last: 1'b0});
        rep_ms[b] = s.stamp;
      end
    end
    if (evs.size() != 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) event_q.push_back(evs[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        forecast_key_events('{btn: s_axis_tdata[3:0], lvl: s_axis_tdata[4],
                              stamp: s_axis_tdata[36:5]});
        items_taken <= items_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          next_sample = sample_q.pop_front();
          s_axis_tdata  <= {3'b0, next_sample.stamp, next_sample.lvl, next_sample.btn};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once, while the sender keeps offering samples
  always @(posedge clk_i) begin
    if (!hold_done && items_taken >= 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Event monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_ev = '{btn: m_axis_tdata[3:0], pressed: m_axis_tuser, last: m_axis_tlast};
        if (event_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected key event: button %0d pressed %0b last %0b",
                     seen_ev.btn, seen_ev.pressed, seen_ev.last);
        end else begin
          want_ev = event_q.pop_front();
          if (seen_ev != want_ev) begin
            mismatches++;
            if (mismatches <= 10)
              $display("key event mismatch: exp button %0d pressed %0b last %0b, %s",
                       want_ev.btn, want_ev.pressed, want_ev.last,
                       $sformatf("got button %0d pressed %0b last %0b",
                                 seen_ev.btn, seen_ev.pressed, seen_ev.last));
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 12);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_sample(int b, logic lvl, logic [bda_pkg::TS_W-1:0] t);
    sample_q.push_back('{btn: bda_pkg::BTN_W'(b), lvl: lvl, stamp: t});
    queued++;
  endtask

  // one press/hold/release cycle with contact bounce at both ends
  task automatic key_stroke(int b);
    int unsigned deb;
    int unsigned dly;
    int unsigned per;
    int          n;
    deb = cfg_m.settle_ms;
    dly = cfg_m.rpt_delay_ms;
    per = cfg_m.repeat_period_ms;
    n = $urandom_range(0, 3);
    repeat (n) begin
      queue_sample(b, 1'b0, wall_ms);
      wall_ms += $urandom_range(0, deb);
      queue_sample(b, 1'b1, wall_ms);
      wall_ms += $urandom_range(0, deb);
    end
    queue_sample(b, 1'b0, wall_ms);
    wall_ms += deb + $urandom_range(0, 2);   // right on the debounce limit now and then
    queue_sample(b, 1'b0, wall_ms);
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0)
        wall_ms += dly + 1 + $urandom_range(0, per);
      else
        wall_ms += $urandom_range(0, dly / 4 + per + 2);
      if ($urandom_range(0, 7) == 0) begin
        // short glitch towards released while held
        queue_sample(b, 1'b1, wall_ms);
        wall_ms += $urandom_range(0, deb);
      end
      queue_sample(b, 1'b0, wall_ms);
    end
    n = $urandom_range(0, 2);
    repeat (n) begin
      wall_ms += $urandom_range(0, deb);
      queue_sample(b, 1'b1, wall_ms);
      wall_ms += $urandom_range(0, deb);
      queue_sample(b, 1'b0, wall_ms);
    end
    queue_sample(b, 1'b1, wall_ms);
    wall_ms += deb + $urandom_range(0, 2);
    queue_sample(b, 1'b1, wall_ms);
    wall_ms += 1 + $urandom_range(0, 3);
    queue_sample(b, 1'b1, wall_ms);
  endtask

  task automatic noise_sample();
    if ($urandom_range(0, 3) == 0)
      wall_ms = $urandom;
    else
      wall_ms += $urandom_range(0, cfg_m.settle_ms + cfg_m.rpt_delay_ms
                                   + cfg_m.repeat_period_ms + 2);
    queue_sample($urandom_range(0, NBTN - 1), 1'($urandom_range(0, 1)), wall_ms);
  endtask

  // register write over APB: setup cycle, then access cycle
  task automatic apb_write(logic [1:0] idx, logic [bda_pkg::CFG_W-1:0] val);
    logic [bda_pkg::DATA_W-1:0] junk;
    junk = $urandom;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[bda_pkg::DATA_W-1:bda_pkg::CFG_W], val};   // upper bits are not stored
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      bda_pkg::REG_DEBOUNCE:     cfg_m.settle_ms          = val;
      bda_pkg::REG_REPEAT_DELAY: cfg_m.rpt_delay_ms       = val;
      bda_pkg::REG_REPEAT_PER:   cfg_m.repeat_period_ms   = val;
      bda_pkg::REG_REPEAT_MASK:  cfg_m.repeat_enable_mask = val;
      default: ;
    endcase
  endtask

  // wait until all samples are taken and all events have come out
  task automatic drain();
    while (sample_q.size() != 0 || s_axis_tvalid || event_q.size() != 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bda_pkg::cfg_t setting;
    int            target;
    cfg_m = '{bda_pkg::RST_DEBOUNCE, bda_pkg::RST_REPEAT_DELAY,
              bda_pkg::RST_REPEAT_PER, bda_pkg::RST_REPEAT_MASK};
    for (int i = 0; i < NBTN; i++) begin
      raw_lvl[i]    = 1'b1;
      stable_lvl[i] = 1'b1;
      key_held[i]   = 1'b0;
      auto_rep[i]   = 1'b0;
      chg_ms[i]     = '0;
      press_ms[i]   = '0;
      rep_ms[i]     = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset settings (button 9 may repeat)
    queue_sample(0,  1'b1, 32'd0);           // released level, nothing changes
    queue_sample(9,  1'b0, 32'd1000);
    queue_sample(9,  1'b0, 32'd1020);        // held exactly the debounce time
    queue_sample(9,  1'b0, 32'd1021);        // press
    queue_sample(9,  1'b0, 32'd1521);        // exactly the repeat delay
    queue_sample(9,  1'b0, 32'd1522);        // repeat starts, no event
    queue_sample(9,  1'b0, 32'd1622);
    queue_sample(9,  1'b0, 32'd1623);        // release/press pair
    queue_sample(9,  1'b1, 32'd1700);        // glitch while held
    queue_sample(9,  1'b0, 32'd1710);
    queue_sample(9,  1'b1, 32'd1800);
    queue_sample(9,  1'b1, 32'd1821);        // release
    queue_sample(3,  1'b0, 32'd2000);
    queue_sample(3,  1'b0, 32'd2100);        // press, mask bit clear
    queue_sample(3,  1'b0, 32'd9000);        // no repeat for this key
    queue_sample(3,  1'b1, 32'd9001);
    queue_sample(3,  1'b1, 32'd9100);
    queue_sample(15, 1'b0, 32'hFFFF_FFF0);
    queue_sample(15, 1'b0, 32'h0000_0005);   // time difference across the wrap
    queue_sample(15, 1'b1, 32'h0000_0010);
    queue_sample(15, 1'b1, 32'h0000_0030);
    queue_sample(0,  1'b0, 32'h8000_0000);
    queue_sample(0,  1'b0, 32'h8000_1000);
    queue_sample(0,  1'b1, 32'h8000_1001);
    queue_sample(0,  1'b1, 32'hFFFF_FFFF);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       setting = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
        1:       setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hAAAA};
        2:       setting = '{16'h0000, 16'hFFFF, 16'h0000, 16'h5555};
        3:       setting = '{16'd5, 16'd40, 16'd10, 16'hFFFF};
        default: setting = '{bda_pkg::CFG_W'($urandom_range(0, 30)),
                             bda_pkg::CFG_W'($urandom_range(0, 200)),
                             bda_pkg::CFG_W'($urandom_range(0, 60)),
                             bda_pkg::CFG_W'($urandom)};
      endcase
      apb_write(bda_pkg::REG_DEBOUNCE,     setting.settle_ms);
      apb_write(bda_pkg::REG_REPEAT_DELAY, setting.rpt_delay_ms);
      apb_write(bda_pkg::REG_REPEAT_PER,   setting.repeat_period_ms);
      apb_write(bda_pkg::REG_REPEAT_MASK,  setting.repeat_enable_mask);
      wall_ms = (p == 3) ? 32'hFFFF_F000 : $urandom;   // one phase runs over the wrap
      target = queued + PHASE_ITEMS;
      while (queued < target) begin
        if ($urandom_range(0, 3) != 0)
          key_stroke($urandom_range(0, NBTN - 1));
        else
          noise_sample();
      end
      drain();
    end

    if (mismatches == 0 && event_q.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bda_pkg.sv
hw/rtl/bda_front.sv
hw/rtl/bda_queue.sv
hw/rtl/bda_back.sv
hw/rtl/button_debounce_autorepeat.sv
tb/tb_top.sv
